FILE: rtl/core/lcd_pkg.sv
// Shared types, constants and search helpers for the lift collective dispatcher.
// No dependencies; every other file of the block except lcd_stream_if imports this package.
package lcd_pkg;

    localparam int FLOOR_W = 4;
    localparam int MASK_W  = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [FLOOR_W-1:0] floor_t;
    typedef logic [1:0]         mode_t;
    typedef logic [0:0]         reg_idx_t;

    // Collection modes; the unused code behaves as full collective
    localparam mode_t MODE_DOWN = 2'd0;
    localparam mode_t MODE_UP   = 2'd1;
    localparam mode_t MODE_FULL = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam reg_idx_t REG_MODE = 1'b0;
    localparam reg_idx_t REG_TOP  = 1'b1;

    localparam mode_t  MODE_RESET = MODE_FULL;
    localparam floor_t TOP_RESET  = 4'd15;

    // One request item
    typedef struct packed {
        mask_t  car_calls;
        mask_t  hall_calls_down;
        mask_t  hall_calls_up;
        floor_t current_floor;
        logic   full_load;
        logic   in_motion;
        logic   stopping;
        logic   maintenance;
    } req_t;

    // One result item
    typedef struct packed {
        logic   target_valid;
        floor_t target_floor;
        logic   arrow_up;
        logic   arrow_down;
        logic   arrows_write;
        logic   drop_all;
    } res_t;

    // Configuration register contents
    typedef struct packed {
        mode_t  collect_mode;
        floor_t top_floor;
    } cfg_t;

    // Outcome of one priority search
    typedef struct packed {
        logic   found;
        floor_t floor;
    } hit_t;

    localparam hit_t HIT_NONE = '{found: 1'b0, floor: '0};

    // Lowest set bit
    function automatic hit_t find_lo(input mask_t m);
        hit_t r;
        r = HIT_NONE;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                r.found = 1'b1;
                r.floor = FLOOR_W'(i);
            end
        end
        return r;
    endfunction

    // Highest set bit
    function automatic hit_t find_hi(input mask_t m);
        hit_t r;
        r = HIT_NONE;
        for (int i = 0; i < MASK_W; i++) begin
            if (m[i]) begin
                r.found = 1'b1;
                r.floor = FLOOR_W'(i);
            end
        end
        return r;
    endfunction

    // Floors at or above f
    function automatic mask_t ge_mask(input floor_t f);
        mask_t m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (FLOOR_W'(i) >= f);
        end
        return m;
    endfunction

    // Floors at or below f
    function automatic mask_t le_mask(input floor_t f);
        mask_t m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (FLOOR_W'(i) <= f);
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/lcd_stream_if.sv
// Valid/ready channel interface carrying one payload per transfer.
// Payload type is a parameter; used with lcd_pkg::req_t and lcd_pkg::res_t.
interface lcd_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/core/lcd_cfg_regs.sv
// APB-style configuration registers: collection mode and top floor.
// Depends on lcd_pkg.
module lcd_cfg_regs
    import lcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    reg_idx_t reg_idx;
    logic     wr_en;
    mode_t    mode_reg;
    mode_t    mode_next;
    floor_t   top_reg;
    floor_t   top_next;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write decode
    always_comb
    begin
        mode_next = mode_reg;
        top_next  = top_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE: mode_next = pwdata[1:0];
                REG_TOP:  top_next  = pwdata[FLOOR_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            top_reg  <= TOP_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            top_reg  <= top_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_MODE: prdata = {{(APB_DW-2){1'b0}}, mode_reg};
            REG_TOP:  prdata = {{(APB_DW-FLOOR_W){1'b0}}, top_reg};
            default:  prdata = '0;
        endcase
    end

    assign cfg.collect_mode = mode_reg;
    assign cfg.top_floor    = top_reg;

endmodule

FILE: rtl/core/lcd_decide.sv
// Combinational dispatch decision: priority searches per collection mode,
// direction reversal and arrow drive. Depends on lcd_pkg.
module lcd_decide
    import lcd_pkg::*;
#(
    parameter int NUM_FLOORS = 16
) (
    input  req_t item,
    input  cfg_t cfg,
    input  logic going_up,
    output res_t result,
    output logic going_up_next
);

    localparam int     MaxFloorInt = (NUM_FLOORS - 1 > MASK_W - 1) ? MASK_W - 1 : NUM_FLOORS - 1;
    localparam floor_t MAX_FLOOR   = FLOOR_W'(MaxFloorInt);

    floor_t lim;
    floor_t cur;
    logic   fw;
    logic   drop;
    mask_t  lim_m;
    mask_t  ge_c;
    mask_t  le_c;
    mask_t  car;
    mask_t  dn;
    mask_t  up;

    hit_t up_car, up_dn, up_cu;
    hit_t dn_car, dn_dn, dn_cd;
    hit_t hi_cd, hi_dn, lo_cd, lo_up;
    hit_t fu_raw, fd_raw;

    hit_t dc_up, dc_dn, uc_up, uc_dn, fc_up, fc_dn;
    logic dc_pre, uc_pre, fc_pre;

    hit_t r_up, r_dn, first, second, pick;
    logic pre, busy, full_mode;

    // Search window
    assign cur   = item.current_floor;
    assign fw    = item.full_load;
    assign lim   = (cfg.top_floor > MAX_FLOOR) ? MAX_FLOOR : cfg.top_floor;
    assign drop  = (cur > cfg.top_floor) || (cur > MAX_FLOOR);
    assign lim_m = le_mask(lim);
    assign ge_c  = ge_mask(cur) & lim_m;
    assign le_c  = le_mask(cur) & lim_m;
    assign car   = item.car_calls & lim_m;
    assign dn    = item.hall_calls_down & lim_m;
    assign up    = item.hall_calls_up & lim_m;

    // Priority encoders
    assign up_car = find_lo(car & ge_c);
    assign up_dn  = find_lo(dn & ge_c);
    assign up_cu  = find_lo((car | up) & ge_c);
    assign dn_car = find_hi(car & le_c);
    assign dn_dn  = find_hi(dn & le_c);
    assign dn_cd  = find_hi((car | dn) & le_c);
    assign hi_cd  = find_hi(car | dn);
    assign hi_dn  = find_hi(dn);
    assign lo_cd  = find_lo(car | dn);
    assign lo_up  = find_lo(up);

    // Down collective: upward phase serves car calls, else heads for the top call
    assign dc_pre = ((item.car_calls | item.hall_calls_down) == '0)
                    || (fw && (item.car_calls == '0));
    assign dc_up  = up_car.found ? up_car : ((!fw && up_dn.found) ? hi_cd : HIT_NONE);
    assign dc_dn  = fw ? dn_car : dn_cd;

    // Up collective: downward phase serves car calls, else heads for the bottom call
    assign uc_pre = (!fw && ((item.car_calls | item.hall_calls_down) == '0))
                    || (fw && (item.car_calls == '0));
    assign uc_dn  = dn_car.found ? dn_car : ((!fw && dn_dn.found) ? lo_cd : HIT_NONE);
    assign uc_up  = fw ? up_car : up_cu;

    // Full collective
    assign fc_pre = (!fw && ((item.car_calls | item.hall_calls_down | item.hall_calls_up) == '0))
                    || (fw && (item.car_calls == '0));
    assign fu_raw = up_cu.found ? up_cu : hi_dn;
    assign fd_raw = dn_cd.found ? dn_cd : lo_up;
    assign fc_up  = fw ? up_car : ((fu_raw.found && fu_raw.floor < cur) ? HIT_NONE : fu_raw);
    assign fc_dn  = fw ? dn_car : ((fd_raw.found && fd_raw.floor > cur) ? HIT_NONE : fd_raw);

    // Mode select
    always_comb
    begin
        case (cfg.collect_mode)
            MODE_DOWN:
            begin
                pre = dc_pre; r_up = dc_up; r_dn = dc_dn;
                busy = item.in_motion; full_mode = 1'b0;
            end
            MODE_UP:
            begin
                pre = uc_pre; r_up = uc_up; r_dn = uc_dn;
                busy = item.in_motion; full_mode = 1'b0;
            end
            default:
            begin
                pre = fc_pre; r_up = fc_up; r_dn = fc_dn;
                busy = item.in_motion || item.stopping; full_mode = 1'b1;
            end
        endcase
    end

    assign first  = going_up ? r_up : r_dn;
    assign second = going_up ? r_dn : r_up;

    // Ahead first, then one reversal when stationary
    always_comb
    begin
        pick          = HIT_NONE;
        going_up_next = going_up;
        if (drop || pre)
        begin
            pick = HIT_NONE;
        end
        else if (first.found)
        begin
            pick = first;
        end
        else if (busy)
        begin
            pick = HIT_NONE;
        end
        else if (full_mode)
        begin
            // full collective only looks back from the up direction
            if (going_up && second.found)
            begin
                pick          = second;
                going_up_next = 1'b0;
            end
            else
            begin
                going_up_next = 1'b1;
            end
        end
        else if (second.found)
        begin
            pick          = second;
            going_up_next = !going_up;
        end
    end

    // Result fields
    assign result.target_valid = pick.found;
    assign result.target_floor = pick.found ? pick.floor : '0;
    assign result.arrow_up     = pick.found && going_up_next;
    assign result.arrow_down   = pick.found && !going_up_next;
    assign result.arrows_write = pick.found || !item.maintenance;
    assign result.drop_all     = drop;

endmodule

FILE: rtl/core/lift_collective_dispatcher_top.sv
// Lift collective dispatcher. Takes one request transfer per clock unless res.ready
// holds the result: the item is captured in an input register, the decision is
// made combinationally and the result is held in an output register, which the
// item enters once that register is free or its result is taken. A new
// request is taken while a finished result still waits downstream. The travel
// direction bit updates as each item moves into the output register. Registers:
// collect_mode at byte 0, top_floor at byte 4; write them only while idle.
module lift_collective_dispatcher_top
    import lcd_pkg::*;
#(
    parameter int NUM_FLOORS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    lcd_stream_if.sink        req,
    lcd_stream_if.source      res
);

    cfg_t cfg;
    req_t item_reg;
    res_t res_data_reg;
    res_t dec_result;
    logic item_valid_reg;
    logic item_valid_next;
    logic res_valid_reg;
    logic res_valid_next;
    logic going_up_reg;
    logic going_up_next;
    logic dec_going_up;
    logic req_fire;
    logic advance;

    lcd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcd_decide #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_decide (
        .item          (item_reg),
        .cfg           (cfg),
        .going_up      (going_up_reg),
        .result        (dec_result),
        .going_up_next (dec_going_up)
    );

    // Pipeline flow control
    assign advance   = item_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready = !item_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    assign item_valid_next = req_fire ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
    assign res_valid_next  = advance ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);
    assign going_up_next   = advance ? dec_going_up : going_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            going_up_reg   <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
            going_up_reg   <= going_up_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg <= req.data;
        end
        if (advance)
        begin
            res_data_reg <= dec_result;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

endmodule

FILE: rtl/core/lcd_checker.sv
// Port-level assertions for the lift collective dispatcher, bound to the top.
// Depends on lcd_pkg and lift_collective_dispatcher_top.
module lcd_checker
    import lcd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input res_t res_data
);

    // Out-of-range floor never yields a target
    a_drop_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.drop_all |-> !res_data.target_valid)
        else $error("drop_all with a target");

    // No target: floor reads zero and both arrows are dark
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.target_valid |->
            res_data.target_floor == '0 && !res_data.arrow_up && !res_data.arrow_down)
        else $error("idle result carries floor or arrows");

    // A target always writes exactly one arrow
    a_target_arrow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.target_valid |->
            res_data.arrows_write && $onehot({res_data.arrow_up, res_data.arrow_down}))
        else $error("target without a single arrow");

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result dropped or changed while stalled");

endmodule

bind lift_collective_dispatcher_top lcd_checker u_lcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
